FILE: rtl/hbs_pkg.sv
// Shared types and constants for the hunting bracket search block.
// Used by the top level; depends on nothing else.
package hbs_pkg;

  // Fixed field widths of the stream beats and the count register
  localparam int POS_W      = 11;
  localparam int STAT_W     = 2;
  localparam int CNT_W      = 11;
  localparam int IDX_IN_W   = 11;
  localparam int KEY_IN_W   = 32;
  localparam int IN_TDATA_W  = 48;  // entry_index + key_value, padded to bytes
  localparam int OUT_TDATA_W = 16;  // position, padded to bytes

  // Parameter defaults
  localparam int DEF_TABLE_DEPTH = 1024;
  localparam int DEF_KEY_WIDTH   = 32;

  // Reset value of the point count register
  localparam logic [CNT_W-1:0] CNT_RESET = 11'd1024;

  // Item modes
  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_SEARCH = 1'b1;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_INSIDE = 2'd0;
  localparam logic [STAT_W-1:0] ST_BELOW  = 2'd1;
  localparam logic [STAT_W-1:0] ST_ABOVE  = 2'd2;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_FIRST,
    S_LAST,
    S_HUNT_LO,
    S_HUNT_HI,
    S_BIS,
    S_DONE
  } state_t;

  // Search phase a step continues from
  typedef enum logic [1:0] {
    PH_HUNT_LO,
    PH_HUNT_HI,
    PH_BIS
  } phase_t;

endpackage

FILE: rtl/hunting_bracket_search.sv
// Top level of the hunting bracket search block: sequencer, compare unit and brackets.
// Depends on hbs_pkg and hbs_ram.
//
// The block keeps an ascending table of signed keys in a RAM, loaded one entry per
// beat with mode 0, and answers each mode 1 beat with the one-based index of the
// entry at or below the key (status inside), or 0 / count plus one with status
// below / above. A load beat gives no result. A search beat runs on one RAM read
// port and one key comparator: states S_FIRST and S_LAST check the first and last
// entries, then each hunting or bisection step does one RAM read and one compare,
// and S_DONE hands the result to the output register. Reused brackets that have to
// be widened by hunting add hunting steps before the bisection. The input is not
// ready while a search runs. The output register lets the result wait while the
// next beat is taken.
module hunting_bracket_search #(
  parameter int TABLE_DEPTH = hbs_pkg::DEF_TABLE_DEPTH,
  parameter int KEY_WIDTH   = hbs_pkg::DEF_KEY_WIDTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [hbs_pkg::IN_TDATA_W-1:0]    in_tdata,   // [10:0] entry_index, [42:11] key_value
  input  logic                              in_tuser,   // [0] mode
  // result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [hbs_pkg::OUT_TDATA_W-1:0]   out_tdata,  // [10:0] position
  output logic [hbs_pkg::STAT_W-1:0]        out_tuser,  // [1:0] status
  // configuration
  input  logic                              cfg_wr_en,
  input  logic [hbs_pkg::CNT_W-1:0]         cfg_wr_data
);

  import hbs_pkg::*;

  localparam int AW     = $clog2(TABLE_DEPTH);
  localparam int IW_MIN = $clog2(TABLE_DEPTH + 2);
  localparam int IW     = (IW_MIN > POS_W) ? IW_MIN : POS_W;

  // Registers
  state_t                 state_r, state_nxt;
  logic signed [KEY_WIDTH-1:0] key_r, key_nxt;
  logic [IW-1:0]          lo_r, lo_nxt;
  logic [IW-1:0]          hi_r, hi_nxt;
  logic [POS_W-1:0]       low_r, low_nxt;
  logic [POS_W-1:0]       high_r, high_nxt;
  logic [CNT_W-1:0]       point_count_r, point_count_nxt;
  logic [POS_W-1:0]       res_pos_r, res_pos_nxt;
  logic [STAT_W-1:0]      res_stat_r, res_stat_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [POS_W-1:0]       out_pos_r, out_pos_nxt;
  logic [STAT_W-1:0]      out_stat_r, out_stat_nxt;

  // Input field unpacking
  logic [IDX_IN_W-1:0]         in_idx;
  logic [KEY_IN_W-1:0]         in_key;
  logic signed [63:0]          in_key64;
  logic signed [KEY_WIDTH-1:0] in_key_w;
  logic                        in_fire;

  assign in_idx    = in_tdata[IDX_IN_W-1:0];
  assign in_key    = in_tdata[IDX_IN_W +: KEY_IN_W];
  assign in_key64  = 64'(signed'(in_key));
  assign in_key_w  = in_key64[KEY_WIDTH-1:0];
  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  // Table RAM
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [AW-1:0]        ram_raddr;
  logic [KEY_WIDTH-1:0] ram_rdata;
  logic [IW-1:0]        rd_idx;

  assign ram_we    = in_fire && (in_tuser == MODE_LOAD) && (in_idx != '0) &&
                     (32'(in_idx) <= TABLE_DEPTH);
  assign ram_waddr = AW'(in_idx - IDX_IN_W'(1));
  assign ram_raddr = AW'(rd_idx - IW'(1));

  hbs_ram #(
    .WIDTH(KEY_WIDTH),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(ram_waddr),
    .wr_data(in_key_w),
    .rd_addr(ram_raddr),
    .rd_data(ram_rdata)
  );

  // Shared key comparator against the entry read last cycle
  logic key_lt, key_gt;
  assign key_lt = key_r < signed'(ram_rdata);
  assign key_gt = key_r > signed'(ram_rdata);

  // Clamp the count into 1..TABLE_DEPTH
  logic [IW-1:0] cnt_n;
  always_comb begin
    if (point_count_r == '0) begin
      cnt_n = IW'(1);
    end else if (32'(point_count_r) > TABLE_DEPTH) begin
      cnt_n = IW'(TABLE_DEPTH);
    end else begin
      cnt_n = IW'(point_count_r);
    end
  end

  // Stored brackets widened to index width
  logic [IW-1:0] low_ext, high_ext;
  logic          stale;
  assign low_ext  = IW'(low_r);
  assign high_ext = IW'(high_r);
  assign stale    = (low_ext == '0) || (high_ext > cnt_n) || (low_ext >= high_ext);

  // Step arithmetic
  logic [IW:0]   lo_half_w, hunt_w, mid_w, lo_plus1, disp_mid_w;
  logic [IW-1:0] lo_half;
  always_comb begin
    lo_half_w = {1'b0, lo_r} >> 1;
    lo_half   = IW'(lo_half_w);
    if (lo_half == '0) begin
      lo_half = IW'(1);
    end
    hunt_w = ({1'b0, hi_r} + (IW + 1)'(1) + {1'b0, cnt_n}) >> 1;
    mid_w  = ({1'b0, lo_r} + {1'b0, hi_r}) >> 1;
  end

  // Sequencer: next state, read address and bracket updates
  phase_t        start_ph;
  logic          go;
  logic [IW-1:0] lo_c, hi_c;

  always_comb begin
    state_nxt       = state_r;
    key_nxt         = key_r;
    lo_nxt          = lo_r;
    hi_nxt          = hi_r;
    low_nxt         = low_r;
    high_nxt        = high_r;
    point_count_nxt = cfg_wr_en ? cfg_wr_data : point_count_r;
    res_pos_nxt     = res_pos_r;
    res_stat_nxt    = res_stat_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    out_pos_nxt     = out_pos_r;
    out_stat_nxt    = out_stat_r;
    rd_idx          = IW'(1);
    go              = 1'b0;
    start_ph        = PH_HUNT_LO;
    lo_c            = lo_r;
    hi_c            = hi_r;
    lo_plus1        = '0;
    disp_mid_w      = '0;

    case (state_r)
      S_IDLE: begin
        // Start a search; load beats are written straight into the RAM
        if (in_fire && (in_tuser == MODE_SEARCH)) begin
          key_nxt   = in_key_w;
          rd_idx    = IW'(1);
          state_nxt = S_FIRST;
        end
      end
      S_FIRST: begin
        // Compare against the first entry
        if (key_lt) begin
          res_pos_nxt  = '0;
          res_stat_nxt = ST_BELOW;
          state_nxt    = S_DONE;
        end else begin
          rd_idx    = cnt_n;
          state_nxt = S_LAST;
        end
      end
      S_LAST: begin
        // Compare against the last entry in use, then pick the brackets
        if (key_gt) begin
          res_pos_nxt  = POS_W'(cnt_n + IW'(1));
          res_stat_nxt = ST_ABOVE;
          state_nxt    = S_DONE;
        end else begin
          go       = 1'b1;
          start_ph = PH_HUNT_LO;
          lo_c     = stale ? IW'(1) : low_ext;
          hi_c     = stale ? cnt_n : high_ext;
        end
      end
      S_HUNT_LO: begin
        // Halve the low bracket while the key is below its entry
        go = 1'b1;
        if (key_lt) begin
          lo_c     = lo_half;
          start_ph = PH_HUNT_LO;
        end else begin
          start_ph = PH_HUNT_HI;
        end
      end
      S_HUNT_HI: begin
        // Move the high bracket halfway to the count while the key is above it
        go = 1'b1;
        if (key_gt) begin
          hi_c     = IW'(hunt_w);
          start_ph = PH_HUNT_HI;
        end else begin
          start_ph = PH_BIS;
        end
      end
      S_BIS: begin
        // Bisect on the midpoint entry
        go       = 1'b1;
        start_ph = PH_BIS;
        if (!key_lt) begin
          lo_c = IW'(mid_w);
        end else begin
          hi_c = IW'(mid_w);
        end
      end
      S_DONE: begin
        // Hand the result to the output register once it is free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_pos_nxt   = res_pos_r;
          out_stat_nxt  = res_stat_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Dispatch the next step from the updated brackets
    if (go) begin
      lo_nxt     = lo_c;
      hi_nxt     = hi_c;
      lo_plus1   = {1'b0, lo_c} + (IW + 1)'(1);
      disp_mid_w = ({1'b0, lo_c} + {1'b0, hi_c}) >> 1;
      if ((start_ph == PH_HUNT_LO) && (lo_c > IW'(1))) begin
        rd_idx    = lo_c;
        state_nxt = S_HUNT_LO;
      end else if ((start_ph != PH_BIS) && (hi_c < cnt_n)) begin
        rd_idx    = hi_c;
        state_nxt = S_HUNT_HI;
      end else if ({1'b0, hi_c} > lo_plus1) begin
        rd_idx    = IW'(disp_mid_w);
        state_nxt = S_BIS;
      end else begin
        res_pos_nxt  = lo_c[POS_W-1:0];
        res_stat_nxt = ST_INSIDE;
        low_nxt      = lo_c[POS_W-1:0];
        high_nxt     = hi_c[POS_W-1:0];
        state_nxt    = S_DONE;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_valid_r   <= 1'b0;
      point_count_r <= CNT_RESET;
      low_r         <= '0;
      high_r        <= '0;
    end else begin
      state_r       <= state_nxt;
      out_valid_r   <= out_valid_nxt;
      point_count_r <= point_count_nxt;
      low_r         <= low_nxt;
      high_r        <= high_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    key_r      <= key_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    res_pos_r  <= res_pos_nxt;
    res_stat_r <= res_stat_nxt;
    out_pos_r  <= out_pos_nxt;
    out_stat_r <= out_stat_nxt;
  end

  // Output beat
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(out_pos_r);
  assign out_tuser  = out_stat_r;

endmodule

FILE: rtl/hbs_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Stand-alone; no package dependency.
module hbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write on enable, read every cycle into the output register
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
